FILE: rtl/t2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2d_pkg: shared types and constants of the track 2 equivalent decoder
// Nibble codes, result kinds, the run summary record and the default sizes.
// ----------------------------------------------------------------------------
package t2d_pkg;

   localparam int SYMBOL_LIMIT_DEF   = 40;
   localparam int PAN_MAX_DIGITS_DEF = 19;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [3:0] SEP_NIBBLE = 4'hD;
   localparam logic [3:0] DIGIT_MAX  = 4'd9;
   localparam logic [2:0] EXP_SYMS   = 3'd4;

   localparam logic KIND_DIGIT   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Per-run summary handed from the scanner to the emitter
   typedef struct packed {
      logic                 pan_ok;
      logic [4:0]           plen;      // zero when no PAN was taken
      logic                 exp_ok;
      logic [3:0][3:0]      exp_sym;   // [0] is the first symbol after the separator
   } summ_type;

   localparam int SUMM_W = $bits(summ_type);

   // 10*hi + lo on two decimal symbols
   function automatic logic [6:0] two_digit(logic [3:0] hi, logic [3:0] lo);
      logic [6:0] h;
      h = {3'b000, hi};
      return (h << 3) + (h << 1) + {3'b000, lo};
   endfunction

endpackage

FILE: rtl/t2d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2d_front: byte scanner
// Classifies both nibbles of a byte together, keeps PAN and expiry symbols,
// and pushes one run record into the queue on the final byte.
// ----------------------------------------------------------------------------
module t2d_front #(
   parameter int SYMBOL_LIMIT   = t2d_pkg::SYMBOL_LIMIT_DEF,
   parameter int PAN_MAX_DIGITS = t2d_pkg::PAN_MAX_DIGITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          byte_valid,
   input  logic [7:0]                    track_byte,
   input  logic                          final_byte,
   input  logic                          pan_known,
   input  logic                          expiry_known,
   input  logic                          queue_full,
   output logic                          byte_ready,
   output logic                          push,
   output t2d_pkg::summ_type             push_summ,
   output logic [PAN_MAX_DIGITS*4-1:0]   push_digits
);

   localparam int CntW    = $clog2(SYMBOL_LIMIT + 1);
   localparam int PanIdxW = (PAN_MAX_DIGITS > 1) ? $clog2(PAN_MAX_DIGITS) : 1;

   typedef struct packed {
      logic [CntW-1:0] sym;
      logic            stop;
      logic            sep;
      logic [CntW-1:0] pre;
      logic [2:0]      post;
      logic            bad;
   } scan_type;

   typedef struct packed {
      scan_type st;
      logic     pan_we;
      logic     exp_we;
   } step_type;

   function automatic step_type nib_step(scan_type s, logic [3:0] nib);
      step_type r;
      logic     dig;
      dig      = (nib <= t2d_pkg::DIGIT_MAX);
      r.st     = s;
      r.pan_we = 1'b0;
      r.exp_we = 1'b0;
      if (!s.stop) begin
         if (32'(s.sym) >= SYMBOL_LIMIT || (!dig && nib != t2d_pkg::SEP_NIBBLE)) begin
            r.st.stop = 1'b1;
         end else begin
            r.st.sym = s.sym + 1'b1;
            if (!s.sep) begin
               if (!dig) begin
                  r.st.sep = 1'b1;
               end else begin
                  r.pan_we = (32'(s.pre) < PAN_MAX_DIGITS);
                  r.st.pre = s.pre + 1'b1;
               end
            end else if (s.post < t2d_pkg::EXP_SYMS) begin
               r.exp_we  = 1'b1;
               r.st.bad  = s.bad | ~dig;
               r.st.post = s.post + 3'd1;
            end
         end
      end
      return r;
   endfunction

   scan_type   scan_ff, scan_in;
   logic [1:0] skip_ff, skip_in;
   logic [3:0] pan_ff [PAN_MAX_DIGITS];
   logic [3:0] pan_in [PAN_MAX_DIGITS];
   logic [3:0] exp_ff [4];
   logic [3:0] exp_in [4];

   step_type   hi_step, lo_step;
   logic [3:0] nib_hi, nib_lo;
   logic       first_byte, accept;
   logic [1:0] skip_eff;
   logic       pan_ok, exp_ok;

   assign nib_hi     = track_byte[7:4];
   assign nib_lo     = track_byte[3:0];
   assign byte_ready = ~queue_full;
   assign accept     = byte_valid & byte_ready;
   assign first_byte = (scan_ff.sym == '0) && !scan_ff.stop;
   assign skip_eff   = first_byte ? {expiry_known, pan_known} : skip_ff;

   always_comb begin
      hi_step = nib_step(scan_ff, nib_hi);
      lo_step = nib_step(hi_step.st, nib_lo);
      for (int k = 0; k < PAN_MAX_DIGITS; k++) begin
         pan_in[k] = pan_ff[k];
         if (hi_step.pan_we && PanIdxW'(scan_ff.pre) == PanIdxW'(k)) pan_in[k] = nib_hi;
         if (lo_step.pan_we && PanIdxW'(hi_step.st.pre) == PanIdxW'(k)) pan_in[k] = nib_lo;
      end
      for (int k = 0; k < 4; k++) begin
         exp_in[k] = exp_ff[k];
         if (hi_step.exp_we && scan_ff.post[1:0] == 2'(k)) exp_in[k] = nib_hi;
         if (lo_step.exp_we && hi_step.st.post[1:0] == 2'(k)) exp_in[k] = nib_lo;
      end
   end

   assign pan_ok = lo_step.st.sep && !skip_eff[0] && (lo_step.st.pre != '0) &&
                   (32'(lo_step.st.pre) <= PAN_MAX_DIGITS);
   assign exp_ok = lo_step.st.sep && !skip_eff[1] &&
                   (lo_step.st.post == t2d_pkg::EXP_SYMS) && !lo_step.st.bad;

   always_comb begin
      push_summ.pan_ok = pan_ok;
      push_summ.plen   = pan_ok ? 5'(lo_step.st.pre) : 5'd0;
      push_summ.exp_ok = exp_ok;
      for (int k = 0; k < 4; k++) push_summ.exp_sym[k] = exp_in[k];
      for (int k = 0; k < PAN_MAX_DIGITS; k++) push_digits[k*4 +: 4] = pan_in[k];
   end

   assign push = accept & final_byte;

   always_comb begin
      scan_in = scan_ff;
      skip_in = skip_ff;
      if (accept) begin
         if (final_byte) begin
            scan_in = '0;
            skip_in = 2'b00;
         end else begin
            scan_in = lo_step.st;
            skip_in = skip_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         skip_ff <= 2'b00;
      end else begin
         scan_ff <= scan_in;
         skip_ff <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pan_ff <= pan_in;
         exp_ff <= exp_in;
      end
   end

`ifndef SYNTHESIS
   a_sym_limit: assert property (@(posedge clock) disable iff (reset)
      32'(scan_ff.sym) <= SYMBOL_LIMIT)
      else $error("symbol count beyond limit");
   a_pre_le_sym: assert property (@(posedge clock) disable iff (reset)
      scan_ff.pre <= scan_ff.sym)
      else $error("PAN digit count exceeds symbol count");
   a_post_after_sep: assert property (@(posedge clock) disable iff (reset)
      scan_ff.post != 3'd0 |-> scan_ff.sep)
      else $error("expiry symbols without separator");
`endif

endmodule

FILE: rtl/t2d_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2d_fifo: run record queue
// Small register queue between the scanner and the emitter.
// ----------------------------------------------------------------------------
module t2d_fifo #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output logic [DATA_W-1:0] head_data
);

   localparam int Depth = t2d_pkg::QUEUE_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   logic [DATA_W-1:0] mem [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full       = (32'(count_ff) == Depth);
   assign head_valid = (count_ff != '0);
   assign head_data  = mem[rd_ptr_ff];

   function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
      return (32'(p) == Depth - 1) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: rtl/t2d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2d_back: result emitter
// Walks the head run record: one PAN digit word per cycle while the receiver is ready, then the summary.
// ----------------------------------------------------------------------------
module t2d_back #(
   parameter int PAN_MAX_DIGITS = t2d_pkg::PAN_MAX_DIGITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  t2d_pkg::summ_type             head_summ,
   input  logic [PAN_MAX_DIGITS*4-1:0]   head_digits,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_kind,
   output logic [3:0]                    rsp_pan_digit,
   output logic [4:0]                    rsp_position,
   output logic                          rsp_pan_captured,
   output logic [4:0]                    rsp_pan_length,
   output logic                          rsp_expiry_captured,
   output logic [6:0]                    rsp_expiry_year,
   output logic [6:0]                    rsp_expiry_month,
   output logic                          rsp_last
);

   localparam int PanIdxW = (PAN_MAX_DIGITS > 1) ? $clog2(PAN_MAX_DIGITS) : 1;

   logic [3:0] digits [PAN_MAX_DIGITS];
   logic [4:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic       kind_ff;
   logic [3:0] digit_ff;
   logic [4:0] position_ff;
   logic       pan_cap_ff;
   logic [4:0] plen_ff;
   logic       exp_cap_ff;
   logic [6:0] year_ff, month_ff;
   logic       load, more;

   always_comb begin
      for (int k = 0; k < PAN_MAX_DIGITS; k++) digits[k] = head_digits[k*4 +: 4];
   end

   assign more = (pos_ff < head_summ.plen);
   assign load = head_valid && (!valid_ff || rsp_ready);
   assign pop  = load && !more;

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         pos_in   = more ? pos_ff + 5'd1 : 5'd0;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 5'd0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (more) begin
            kind_ff     <= t2d_pkg::KIND_DIGIT;
            digit_ff    <= digits[PanIdxW'(pos_ff)];
            position_ff <= pos_ff;
            pan_cap_ff  <= 1'b0;
            plen_ff     <= 5'd0;
            exp_cap_ff  <= 1'b0;
            year_ff     <= 7'd0;
            month_ff    <= 7'd0;
         end else begin
            kind_ff     <= t2d_pkg::KIND_SUMMARY;
            digit_ff    <= 4'd0;
            position_ff <= 5'd0;
            pan_cap_ff  <= head_summ.pan_ok;
            plen_ff     <= head_summ.plen;
            exp_cap_ff  <= head_summ.exp_ok;
            year_ff     <= head_summ.exp_ok ?
                           t2d_pkg::two_digit(head_summ.exp_sym[0], head_summ.exp_sym[1]) : 7'd0;
            month_ff    <= head_summ.exp_ok ?
                           t2d_pkg::two_digit(head_summ.exp_sym[2], head_summ.exp_sym[3]) : 7'd0;
         end
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_pan_digit       = digit_ff;
   assign rsp_position        = position_ff;
   assign rsp_pan_captured    = pan_cap_ff;
   assign rsp_pan_length      = plen_ff;
   assign rsp_expiry_captured = exp_cap_ff;
   assign rsp_expiry_year     = year_ff;
   assign rsp_expiry_month    = month_ff;
   assign rsp_last            = (kind_ff == t2d_pkg::KIND_SUMMARY);

`ifndef SYNTHESIS
   a_pop_on_summary: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid && pos_ff >= head_summ.plen)
      else $error("record popped before all digits were sent");
   a_pos_cleared: assert property (@(posedge clock) disable iff (reset)
      pop |=> pos_ff == 5'd0)
      else $error("digit position not rewound after summary");
   a_digit_pos_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == t2d_pkg::KIND_DIGIT |-> 32'(position_ff) < PAN_MAX_DIGITS)
      else $error("digit position out of range");
`endif

endmodule

FILE: rtl/track2_equivalent_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track2_equivalent_decoder: EMV Track 2 equivalent field parser
// Scans packed track bytes and emits the PAN digits and an expiry summary.
// ----------------------------------------------------------------------------
// The block takes one track byte per cycle on the req_ side while req_tready
// is high, with no gaps needed; both nibbles of a byte are classified in that
// same cycle (high nibble first). The byte flagged by req_tlast closes the
// run: its PAN digits and expiry symbols are packed into a run record and
// queued, and the scanner is back at its reset state for the next run on the
// following cycle. A queue of two run records sits between the scanner and
// the emitter; req_tready drops only while that queue is full. The emitter
// sends one word per cycle on the rsp_ side while rsp_tready is high: one
// digit word per PAN digit (when a PAN of 1 to PAN_MAX_DIGITS digits was
// found and not marked known), then one summary word with rsp_tlast high. A
// run thus costs pan_length + 1 output words; the output pace is what limits
// throughput on short runs. There is no configuration port.
// ----------------------------------------------------------------------------
module track2_equivalent_decoder #(
   parameter int SYMBOL_LIMIT   = t2d_pkg::SYMBOL_LIMIT_DEF,
   parameter int PAN_MAX_DIGITS = t2d_pkg::PAN_MAX_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input word
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] track_byte
   input  logic        req_tlast,   // final_byte
   input  logic [1:0]  req_tuser,   // [0] pan_known, [1] expiry_known
   // result word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [3:0] pan_digit, [8:4] digit_position,
                                    // [9] pan_captured, [14:10] pan_length,
                                    // [15] expiry_captured, [22:16] expiry_year,
                                    // [29:23] expiry_month, [31:30] zero
   output logic        rsp_tlast,   // last_of_run
   output logic        rsp_tuser    // result_kind
);

   localparam int DigW  = PAN_MAX_DIGITS * 4;
   localparam int RecW  = t2d_pkg::SUMM_W + DigW;

   // scanner to queue
   logic                  q_push, q_full;
   t2d_pkg::summ_type     push_summ;
   logic [DigW-1:0]       push_digits;

   // queue to emitter
   logic                  q_pop, q_valid;
   logic [RecW-1:0]       q_head;
   t2d_pkg::summ_type     head_summ;
   logic [DigW-1:0]       head_digits;

   // emitter outputs
   logic       kind;
   logic [3:0] pan_digit;
   logic [4:0] position;
   logic       pan_cap;
   logic [4:0] pan_len;
   logic       exp_cap;
   logic [6:0] yy_field, mm_field;

   t2d_front #(
      .SYMBOL_LIMIT   (SYMBOL_LIMIT),
      .PAN_MAX_DIGITS (PAN_MAX_DIGITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (req_tvalid),
      .track_byte   (req_tdata),
      .final_byte   (req_tlast),
      .pan_known    (req_tuser[0]),
      .expiry_known (req_tuser[1]),
      .queue_full   (q_full),
      .byte_ready   (req_tready),
      .push         (q_push),
      .push_summ    (push_summ),
      .push_digits  (push_digits)
   );

   t2d_fifo #(
      .DATA_W (RecW)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  ({push_summ, push_digits}),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   assign head_summ   = q_head[RecW-1 -: t2d_pkg::SUMM_W];
   assign head_digits = q_head[DigW-1:0];

   t2d_back #(
      .PAN_MAX_DIGITS (PAN_MAX_DIGITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (q_valid),
      .head_summ           (head_summ),
      .head_digits         (head_digits),
      .pop                 (q_pop),
      .rsp_valid           (rsp_tvalid),
      .rsp_ready           (rsp_tready),
      .rsp_kind            (kind),
      .rsp_pan_digit       (pan_digit),
      .rsp_position        (position),
      .rsp_pan_captured    (pan_cap),
      .rsp_pan_length      (pan_len),
      .rsp_expiry_captured (exp_cap),
      .rsp_expiry_year     (yy_field),
      .rsp_expiry_month    (mm_field),
      .rsp_last            (rsp_tlast)
   );

   assign rsp_tuser = kind;
   assign rsp_tdata = {2'b00, mm_field, yy_field, exp_cap, pan_len, pan_cap,
                       position, pan_digit};

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the track 2 equivalent decoder
// Feeds packed track bytes run by run. A scoreboard model of the parser
// predicts every digit word and summary word of a run. Each result word is
// compared field by field as it arrives. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int SYM_LIMIT   = t2d_pkg::SYMBOL_LIMIT_DEF;
   localparam int PAN_MAX     = t2d_pkg::PAN_MAX_DIGITS_DEF;
   localparam int CYCLE_LIMIT = 100000;    // far above the slowest legal run
   localparam int TAIL_CYCLES = 30;        // settle time once nothing is owed
   localparam logic [3:0] FILL_NIBBLE = 4'hF;   // pad / stop nibble

   // One expected result word, unpacked
   typedef struct {
      logic       kind;
      logic [3:0] digit;
      logic [4:0] pos;
      logic       pan_cap;
      logic [4:0] pan_len;
      logic       exp_cap;
      logic [6:0] year;
      logic [6:0] month;
      logic       last;
   } track_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   track_word_type expected_words[$];
   track_word_type arrived_want;
   logic [3:0]  run_nibbles[$];     // symbols of the run being built
   int          error_count;
   int          cycle_count;
   int          send_idle_pct;
   int          recv_idle_pct;

   // scoreboard copy of the parser state
   int unsigned sym_count;
   bit          scan_stopped;
   bit          sep_seen;
   int unsigned pre_count;
   int unsigned post_count;
   bit          exp_bad;
   logic [1:0]  skip_flags;          // [0] PAN suppressed, [1] expiry suppressed
   logic [3:0]  pan_digits[PAN_MAX];
   logic [3:0]  exp_syms[4];

   track2_equivalent_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Scoreboard model
   // ------------------------------------------------------------------------
   function automatic void clear_scan();
      sym_count    = 0;
      scan_stopped = 1'b0;
      sep_seen     = 1'b0;
      pre_count    = 0;
      post_count   = 0;
      exp_bad      = 1'b0;
      skip_flags   = 2'b00;
   endfunction

   function automatic void scan_nibble(logic [3:0] nib);
      logic is_digit;
      is_digit = (nib <= t2d_pkg::DIGIT_MAX);
      if (scan_stopped)
         return;
      // a stop nibble, or one past the symbol limit, freezes the scan
      if (sym_count >= SYM_LIMIT || (!is_digit && nib != t2d_pkg::SEP_NIBBLE)) begin
         scan_stopped = 1'b1;
         return;
      end
      sym_count++;
      if (!sep_seen) begin
         if (!is_digit) begin
            sep_seen = 1'b1;
         end else begin
            if (pre_count < PAN_MAX)
               pan_digits[pre_count] = nib;
            pre_count++;
         end
      end else if (post_count < t2d_pkg::EXP_SYMS) begin
         exp_syms[post_count] = nib;
         if (!is_digit)
            exp_bad = 1'b1;
         post_count++;
      end
   endfunction

   // Advance the model by one accepted byte; on the final byte queue the
   // digit words and the summary word it owes.
   function automatic void track_decode(logic [7:0] tbyte, logic fin, logic [1:0] flags);
      track_word_type w;
      bit          pan_ok;
      bit          exp_ok;
      int unsigned plen;
      if (sym_count == 0 && !scan_stopped)
         skip_flags = flags;
      scan_nibble(tbyte[7:4]);
      scan_nibble(tbyte[3:0]);
      if (!fin)
         return;
      pan_ok = sep_seen && !skip_flags[0] && pre_count > 0 && pre_count <= PAN_MAX;
      exp_ok = sep_seen && !skip_flags[1] && post_count == t2d_pkg::EXP_SYMS && !exp_bad;
      plen   = pan_ok ? pre_count : 0;
      w = '{kind: t2d_pkg::KIND_DIGIT, digit: 4'd0, pos: 5'd0, pan_cap: 1'b0,
            pan_len: 5'd0, exp_cap: 1'b0, year: 7'd0, month: 7'd0, last: 1'b0};
      for (int i = 0; i < plen; i++) begin
         w.digit = pan_digits[i];
         w.pos   = i[4:0];
         expected_words.push_back(w);
      end
      w.kind    = t2d_pkg::KIND_SUMMARY;
      w.digit   = 4'd0;
      w.pos     = 5'd0;
      w.pan_cap = pan_ok;
      w.pan_len = plen[4:0];
      w.exp_cap = exp_ok;
      w.year    = exp_ok ? 7'(exp_syms[0] * 10 + exp_syms[1]) : 7'd0;
      w.month   = exp_ok ? 7'(exp_syms[2] * 10 + exp_syms[3]) : 7'd0;
      w.last    = 1'b1;
      expected_words.push_back(w);
      clear_scan();
   endfunction

   // ------------------------------------------------------------------------
   // Result side: random backpressure and the word checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= (recv_idle_pct == 0) || ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual tdata=%h tlast=%b tuser=%b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
            error_count++;
         end else begin
            arrived_want = expected_words.pop_front();
            check_field("result_kind",     32'(arrived_want.kind),    32'(rsp_tuser));
            check_field("pan_digit",       32'(arrived_want.digit),   32'(rsp_tdata[3:0]));
            check_field("digit_position",  32'(arrived_want.pos),     32'(rsp_tdata[8:4]));
            check_field("pan_captured",    32'(arrived_want.pan_cap), 32'(rsp_tdata[9]));
            check_field("pan_length",      32'(arrived_want.pan_len), 32'(rsp_tdata[14:10]));
            check_field("expiry_captured", 32'(arrived_want.exp_cap), 32'(rsp_tdata[15]));
            check_field("expiry_year",     32'(arrived_want.year),    32'(rsp_tdata[22:16]));
            check_field("expiry_month",    32'(arrived_want.month),   32'(rsp_tdata[29:23]));
            check_field("tdata_pad",       32'd0,                     32'(rsp_tdata[31:30]));
            check_field("last_of_run",     32'(arrived_want.last),    32'(rsp_tlast));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // Optional idle gap, then hold the word until it is taken, then feed it
   // to the model.
   task automatic send_byte(input logic [7:0] tbyte, input logic fin, input logic [1:0] flags);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= tbyte;
      req_tlast  <= fin;
      req_tuser  <= flags;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      track_decode(tbyte, fin, flags);
   endtask

   // Pack run_nibbles two to a byte (high first), pad odd runs with F.
   // Flags matter only on the first byte; later bytes carry random flags.
   task automatic send_run(input logic [1:0] first_flags);
      int nbytes;
      if (run_nibbles.size() % 2 != 0)
         run_nibbles.push_back(FILL_NIBBLE);
      nbytes = run_nibbles.size() / 2;
      for (int i = 0; i < nbytes; i++)
         send_byte({run_nibbles[2*i], run_nibbles[2*i+1]}, i == nbytes - 1,
                   (i == 0) ? first_flags : 2'($urandom_range(0, 3)));
   endtask

   // Drop valid and hold off until every owed word has come back.
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0)
         @(posedge clock);
   endtask

   // Mostly well-formed fields (PAN, separator, YYMM, trailing data, F pad),
   // some with short or broken expiry, the rest plain nibble noise.
   // A long run goes past the symbol limit.
   task automatic build_track_run(input bit long_run);
      int plen;
      int exp_count;
      int extra;
      int bad_at;
      run_nibbles.delete();
      if (long_run || $urandom_range(0, 99) < 75) begin
         plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 22) : $urandom_range(12, 19);
         repeat (plen) run_nibbles.push_back(4'($urandom_range(0, 9)));
         run_nibbles.push_back(t2d_pkg::SEP_NIBBLE);
         exp_count = (!long_run && $urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 4;
         repeat (exp_count) run_nibbles.push_back(4'($urandom_range(0, 9)));
         if (exp_count == 4 && $urandom_range(0, 5) == 0) begin
            // separator or stop nibble inside the expiry
            bad_at = plen + 1 + $urandom_range(0, 3);
            run_nibbles[bad_at] = $urandom_range(0, 1) ? t2d_pkg::SEP_NIBBLE
                                                       : 4'($urandom_range(10, 15));
         end
         if (exp_count < 4)
            extra = 0;
         else if (long_run)
            extra = SYM_LIMIT + 2 - run_nibbles.size() + $urandom_range(0, 6);
         else
            extra = $urandom_range(0, 8);
         repeat (extra)
            run_nibbles.push_back(($urandom_range(0, 15) == 0) ? t2d_pkg::SEP_NIBBLE
                                                              : 4'($urandom_range(0, 9)));
         if ($urandom_range(0, 3) == 0) begin
            // stop, then garbage that must be ignored
            run_nibbles.push_back(FILL_NIBBLE);
            repeat ($urandom_range(1, 5)) run_nibbles.push_back(4'($urandom_range(0, 15)));
         end
      end else begin
         repeat ($urandom_range(1, 16)) run_nibbles.push_back(4'($urandom_range(0, 15)));
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed_runs();
      send_byte(8'hD1, 1'b1, 2'b00);                 // empty PAN, short expiry
      send_byte(8'h1D, 1'b0, 2'b00);                 // PAN 1, expiry 2512
      send_byte(8'h25, 1'b0, 2'b11);
      send_byte(8'h12, 1'b1, 2'b11);
      send_byte(8'h1D, 1'b0, 2'b11);                 // same, both already known
      send_byte(8'h25, 1'b0, 2'b00);
      send_byte(8'h12, 1'b1, 2'b00);
      send_byte(8'h1A, 1'b0, 2'b00);                 // stop nibble, no separator
      send_byte(8'h55, 1'b1, 2'b00);                 // ignored after stop
      send_byte(8'h1D, 1'b0, 2'b10);                 // separator inside expiry
      send_byte(8'h2D, 1'b0, 2'b00);
      send_byte(8'h99, 1'b1, 2'b01);
      send_byte(8'h9D, 1'b0, 2'b01);                 // PAN known, expiry 9999
      send_byte(8'h99, 1'b0, 2'b10);
      send_byte(8'h99, 1'b1, 2'b00);
      // longest PAN that is still taken, expiry 0000
      run_nibbles.delete();
      for (int i = 0; i < PAN_MAX; i++)
         run_nibbles.push_back(4'((i % 2 == 0) ? 9 : 0));
      run_nibbles.push_back(t2d_pkg::SEP_NIBBLE);
      repeat (4) run_nibbles.push_back(4'd0);
      send_run(2'b00);
   endtask

   task automatic test_random_runs(input int send_pct, input int recv_pct, input int budget);
      int sent;
      int runs;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      runs = 0;
      while (sent < budget) begin
         build_track_run(runs == 0);
         sent += (run_nibbles.size() + 1) / 2;
         send_run(2'($urandom_range(0, 3)));
         runs++;
         if (runs == 1)
            pause_until_drained();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tlast     = 1'b0;
      req_tuser     = 2'b00;
      rsp_tready    = 1'b0;
      error_count   = 0;
      cycle_count   = 0;
      send_idle_pct = 22;
      recv_idle_pct = 77;
      clear_scan();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_runs();
      test_random_runs(22, 77, 26);
      test_random_runs(77, 22, 26);
      test_random_runs(0, 0, 26);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_words.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
